/* hdl/pfc_pkg.sv */
// ----------------------------------------------------------------------------
// Playfair cipher engine package
// Shared constants, controller/datapath command and status words, and the
// small helper functions of the letter and key square arithmetic.
// ----------------------------------------------------------------------------
package pfc_pkg;

   localparam int SQ_SIDE  = 5;
   localparam int SQ_CELLS = SQ_SIDE * SQ_SIDE;
   localparam int ALPHA    = 26;

   localparam logic [4:0] IDX_I       = 5'd8;
   localparam logic [4:0] IDX_J       = 5'd9;
   localparam logic [4:0] IDX_X       = 5'd23;
   localparam logic [4:0] LAST_LETTER = 5'(ALPHA - 1);
   localparam logic [4:0] CELLS_FULL  = 5'(SQ_CELLS);

   localparam logic [7:0] ASCII_UA = 8'h41;
   localparam logic [7:0] ASCII_UZ = 8'h5A;
   localparam logic [7:0] ASCII_LA = 8'h61;
   localparam logic [7:0] ASCII_LZ = 8'h7A;
   localparam logic [6:0] LETTER_A = 7'h41;

   localparam logic [ALPHA-1:0] USED_RESET = ALPHA'(1) << IDX_J;

   typedef enum logic [1:0] {
      MODE_KEY  = 2'd0,
      MODE_FIN  = 2'd1,
      MODE_TEXT = 2'd2,
      MODE_END  = 2'd3
   } mode_type;

   typedef struct packed {
      logic accept;
      logic fill_step;
      logic read_pos;
      logic read_cell;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic pair_go;
      logic fill_go;
      logic fill_last;
      logic obuf_empty;
   } sts_type;

   // {valid, index}; J folds to I, non-letters are invalid
   function automatic logic [5:0] to_index(input logic [7:0] c);
      logic [7:0] d;
      logic       ok;
      logic [4:0] idx;
      d  = 8'd0;
      ok = 1'b0;
      if (c >= ASCII_LA && c <= ASCII_LZ) begin
         d  = c - ASCII_LA;
         ok = 1'b1;
      end else if (c >= ASCII_UA && c <= ASCII_UZ) begin
         d  = c - ASCII_UA;
         ok = 1'b1;
      end
      idx = d[4:0];
      if (idx == IDX_J) begin
         idx = IDX_I;
      end
      return {ok, idx};
   endfunction

   function automatic logic [2:0] pos_row(input logic [4:0] p);
      logic [2:0] r;
      if (p < 5'd5) r = 3'd0;
      else if (p < 5'd10) r = 3'd1;
      else if (p < 5'd15) r = 3'd2;
      else if (p < 5'd20) r = 3'd3;
      else r = 3'd4;
      return r;
   endfunction

   function automatic logic [4:0] times5(input logic [2:0] r);
      logic [4:0] r5;
      r5 = {2'b00, r};
      return (r5 << 2) + r5;
   endfunction

   function automatic logic [2:0] pos_col(input logic [4:0] p);
      logic [4:0] c;
      c = p - times5(pos_row(p));
      return c[2:0];
   endfunction

   function automatic logic [2:0] add_mod5(input logic [2:0] v, input logic [2:0] s);
      logic [3:0] sum;
      sum = {1'b0, v} + {1'b0, s};
      if (sum >= 4'(SQ_SIDE)) begin
         sum = sum - 4'(SQ_SIDE);
      end
      return sum[2:0];
   endfunction

   function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
      return times5(r) + {2'b00, c};
   endfunction

endpackage

/* hdl/playfair_cipher_engine.sv */
// ----------------------------------------------------------------------------
// Playfair cipher engine
// Builds a 5x5 key square from keyword words and turns text words into
// enciphered or deciphered digraph letters.
// ----------------------------------------------------------------------------
// A finish word on an unfinished key makes the controller walk the alphabet
// once to fill the rest of the square. A text or end word that completes a
// digraph is followed by two registered memory reads, letter positions and
// then key square cells, before the pair enters the result buffer, which
// waits until the buffer is empty; the two result words then leave one per
// cycle while rsp_tready is high, and new words are already taken meanwhile.
// No word is taken during a fill walk or a lookup. csr_wr_data selects
// decryption when high; write it only while the engine is idle.
module playfair_cipher_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] mode, [9:2] char_in, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] letter, [7] zero
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   pfc_pkg::cmd_type cmd;
   pfc_pkg::sts_type sts;
   logic [6:0]       letter;

   pfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pfc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_mode    (req_tdata[1:0]),
      .req_char    (req_tdata[9:2]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_letter  (letter),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, letter};

endmodule

/* hdl/pfc_ctrl.sv */
// ----------------------------------------------------------------------------
// Playfair controller
// Sequences item acceptance, the alphabet fill walk and the two-step digraph
// lookup, and hands finished pairs to the output buffer.
// ----------------------------------------------------------------------------
module pfc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  pfc_pkg::sts_type sts,
   output pfc_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_POS,
      ST_CELL,
      ST_PUSH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (sts.fill_go) begin
                  state_in = ST_FILL;
               end else if (sts.pair_go) begin
                  state_in = ST_POS;
               end
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_POS: begin
            cmd.read_pos = 1'b1;
            state_in     = ST_CELL;
         end
         ST_CELL: begin
            cmd.read_cell = 1'b1;
            state_in      = ST_PUSH;
         end
         ST_PUSH: begin
            // hold until the previous pair has drained
            if (sts.obuf_empty) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/pfc_dp.sv */
// ----------------------------------------------------------------------------
// Playfair datapath
// Key square and letter position memories, key build state, held text
// letter, digraph rule logic and the two-word result buffer.
// ----------------------------------------------------------------------------
module pfc_dp (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       req_mode,
   input  logic [7:0]       req_char,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   input  pfc_pkg::cmd_type cmd,
   output pfc_pkg::sts_type sts,
   input  logic             rsp_tready,
   output logic             rsp_tvalid,
   output logic [6:0]       rsp_letter,
   output logic             rsp_last
);

   logic [4:0] key_square [pfc_pkg::SQ_CELLS];
   logic [4:0] letter_pos [pfc_pkg::ALPHA];

   logic [pfc_pkg::ALPHA-1:0] used_ff, used_in;
   logic [4:0] fill_ff, fill_in;
   logic       ready_ff, ready_in;
   logic [4:0] held_ff, held_in;
   logic       held_v_ff, held_v_in;
   logic [4:0] fidx_ff, fidx_in;
   logic [4:0] a_ff, a_in;
   logic [4:0] b_ff, b_in;
   logic [4:0] pa_ff, pb_ff;
   logic [4:0] xs_ff, ys_ff;
   logic [4:0] ob_x_ff, ob_y_ff;
   logic [1:0] ob_cnt_ff, ob_cnt_in;
   logic       decrypt_ff;

   logic [5:0] ch;
   logic       ch_ok;
   logic [4:0] ch_idx;
   logic [pfc_pkg::ALPHA-1:0] used_base;
   logic [4:0] fill_base;
   logic [4:0] plc_idx;
   logic       plc_try;
   logic       wr_en;
   logic [4:0] wr_letter;
   logic [4:0] wr_cell;
   pfc_pkg::mode_type mode;

   assign ch     = pfc_pkg::to_index(req_char);
   assign ch_ok  = ch[5];
   assign ch_idx = ch[4:0];
   assign mode   = pfc_pkg::mode_type'(req_mode);

   // word and fill updates; place one letter if there is room and it is new
   always_comb begin
      used_in   = used_ff;
      fill_in   = fill_ff;
      ready_in  = ready_ff;
      held_in   = held_ff;
      held_v_in = held_v_ff;
      fidx_in   = fidx_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      used_base = used_ff;
      fill_base = fill_ff;
      plc_idx   = fidx_ff;
      plc_try   = 1'b0;
      if (cmd.accept) begin
         unique case (mode)
            pfc_pkg::MODE_KEY: begin
               if (ready_ff) begin
                  used_base = pfc_pkg::USED_RESET;
                  fill_base = 5'd0;
                  ready_in  = 1'b0;
                  held_v_in = 1'b0;
               end
               plc_idx = ch_idx;
               plc_try = ch_ok;
            end
            pfc_pkg::MODE_FIN: begin
               if (!ready_ff) begin
                  fidx_in = 5'd0;
               end
            end
            pfc_pkg::MODE_TEXT: begin
               if (ready_ff && ch_ok) begin
                  if (!held_v_ff) begin
                     held_in   = ch_idx;
                     held_v_in = 1'b1;
                  end else if (ch_idx == held_ff) begin
                     // doubled letter: pad with X, keep the held copy
                     a_in = held_ff;
                     b_in = pfc_pkg::IDX_X;
                  end else begin
                     a_in      = held_ff;
                     b_in      = ch_idx;
                     held_v_in = 1'b0;
                  end
               end
            end
            pfc_pkg::MODE_END: begin
               if (ready_ff && held_v_ff) begin
                  a_in      = held_ff;
                  b_in      = pfc_pkg::IDX_X;
                  held_v_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
      if (cmd.fill_step) begin
         plc_idx = fidx_ff;
         plc_try = 1'b1;
         fidx_in = fidx_ff + 5'd1;
         if (fidx_ff == pfc_pkg::LAST_LETTER) begin
            ready_in = 1'b1;
         end
      end
      used_in   = used_base;
      fill_in   = fill_base;
      wr_en     = plc_try && (fill_base < pfc_pkg::CELLS_FULL) && !used_base[plc_idx];
      wr_letter = plc_idx;
      wr_cell   = fill_base;
      if (wr_en) begin
         used_in = used_base | (pfc_pkg::ALPHA'(1) << plc_idx);
         fill_in = fill_base + 5'd1;
      end
   end

   always_comb begin
      sts.fill_go    = (mode == pfc_pkg::MODE_FIN) && !ready_ff;
      sts.pair_go    = ((mode == pfc_pkg::MODE_TEXT) && ready_ff && ch_ok && held_v_ff) ||
                       ((mode == pfc_pkg::MODE_END) && ready_ff && held_v_ff);
      sts.fill_last  = (fidx_ff == pfc_pkg::LAST_LETTER);
      sts.obuf_empty = (ob_cnt_ff == 2'd0);
   end

   // digraph rule on the registered positions
   logic [2:0] r1, c1, r2, c2, step;
   logic [4:0] x_addr, y_addr;

   always_comb begin
      r1   = pfc_pkg::pos_row(pa_ff);
      c1   = pfc_pkg::pos_col(pa_ff);
      r2   = pfc_pkg::pos_row(pb_ff);
      c2   = pfc_pkg::pos_col(pb_ff);
      step = decrypt_ff ? 3'(pfc_pkg::SQ_SIDE - 1) : 3'd1;
      if (r1 == r2) begin
         x_addr = pfc_pkg::cell_addr(r1, pfc_pkg::add_mod5(c1, step));
         y_addr = pfc_pkg::cell_addr(r2, pfc_pkg::add_mod5(c2, step));
      end else if (c1 == c2) begin
         x_addr = pfc_pkg::cell_addr(pfc_pkg::add_mod5(r1, step), c1);
         y_addr = pfc_pkg::cell_addr(pfc_pkg::add_mod5(r2, step), c2);
      end else begin
         x_addr = pfc_pkg::cell_addr(r1, c2);
         y_addr = pfc_pkg::cell_addr(r2, c1);
      end
   end

   always_comb begin
      ob_cnt_in = ob_cnt_ff;
      if (cmd.push) begin
         ob_cnt_in = 2'd2;
      end else if (rsp_tvalid && rsp_tready) begin
         ob_cnt_in = ob_cnt_ff - 2'd1;
      end
   end

   assign rsp_tvalid = (ob_cnt_ff != 2'd0);
   assign rsp_last   = (ob_cnt_ff == 2'd1);
   assign rsp_letter = pfc_pkg::LETTER_A + {2'b00, (rsp_last ? ob_y_ff : ob_x_ff)};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_square[wr_cell]   <= wr_letter;
         letter_pos[wr_letter] <= wr_cell;
      end
      if (cmd.read_pos) begin
         pa_ff <= letter_pos[a_ff];
         pb_ff <= letter_pos[b_ff];
      end
      if (cmd.read_cell) begin
         xs_ff <= key_square[x_addr];
         ys_ff <= key_square[y_addr];
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      if (cmd.push) begin
         ob_x_ff <= xs_ff;
         ob_y_ff <= ys_ff;
      end
      if (reset) begin
         used_ff    <= pfc_pkg::USED_RESET;
         fill_ff    <= 5'd0;
         ready_ff   <= 1'b0;
         held_ff    <= 5'd0;
         held_v_ff  <= 1'b0;
         fidx_ff    <= 5'd0;
         ob_cnt_ff  <= 2'd0;
         decrypt_ff <= 1'b0;
      end else begin
         used_ff   <= used_in;
         fill_ff   <= fill_in;
         ready_ff  <= ready_in;
         held_ff   <= held_in;
         held_v_ff <= held_v_in;
         fidx_ff   <= fidx_in;
         ob_cnt_ff <= ob_cnt_in;
         if (csr_wr_en) begin
            decrypt_ff <= csr_wr_data;
         end
      end
   end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Playfair cipher engine testbench
// Streams keyword, finish, text and end words into the engine with random
// gaps on both sides, predicts every digraph letter from a private copy of
// the key square and the pending text letter, and checks each result word
// in order. A directed opening is followed by random keys and texts under
// both cipher directions.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int SETTLE_CYCLES = 40;
   localparam int ITEM_TARGET   = 2000;

   typedef struct packed {
      logic [6:0] letter;
      logic       last;
   } cipher_letter_type;

   class playfair_tracker;
      logic [4:0]  square [pfc_pkg::SQ_CELLS];
      logic [4:0]  cell_of [pfc_pkg::ALPHA];
      logic [25:0] placed;
      int          filled;
      bit          ready;
      bit          held_v;
      logic [4:0]  held;
      bit          decrypt;
      int          fails;
      cipher_letter_type letters_due [$];

      function new();
         placed  = 26'd1 << pfc_pkg::IDX_J;
         filled  = 0;
         ready   = 1'b0;
         held_v  = 1'b0;
         held    = 5'd0;
         decrypt = 1'b0;
         fails   = 0;
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         fails++;
      endtask

      // letter index with J folded onto I; returns 0 for a non-letter
      function bit letter_index(logic [7:0] ch, output logic [4:0] idx);
         idx = 5'd0;
         if (ch >= "a" && ch <= "z") idx = 5'(ch - "a");
         else if (ch >= "A" && ch <= "Z") idx = 5'(ch - "A");
         else return 1'b0;
         if (idx == pfc_pkg::IDX_J) idx = pfc_pkg::IDX_I;
         return 1'b1;
      endfunction

      function void place(logic [4:0] idx);
         if (filled < pfc_pkg::SQ_CELLS && !placed[idx]) begin
            square[filled] = idx;
            cell_of[idx]   = 5'(filled);
            placed[idx]    = 1'b1;
            filled++;
         end
      endfunction

      function void restart_key();
         placed = 26'd1 << pfc_pkg::IDX_J;
         filled = 0;
         ready  = 1'b0;
         held   = 5'd0;
         held_v = 1'b0;
      endfunction

      function void encipher_pair(logic [4:0] a, logic [4:0] b);
         int pa, pb, r1, c1, r2, c2, shift;
         logic [4:0] x, y;
         pa = cell_of[a];
         pb = cell_of[b];
         r1 = pa / pfc_pkg::SQ_SIDE;
         c1 = pa % pfc_pkg::SQ_SIDE;
         r2 = pb / pfc_pkg::SQ_SIDE;
         c2 = pb % pfc_pkg::SQ_SIDE;
         shift = decrypt ? pfc_pkg::SQ_SIDE - 1 : 1;
         if (r1 == r2) begin
            x = square[r1 * pfc_pkg::SQ_SIDE + (c1 + shift) % pfc_pkg::SQ_SIDE];
            y = square[r2 * pfc_pkg::SQ_SIDE + (c2 + shift) % pfc_pkg::SQ_SIDE];
         end else if (c1 == c2) begin
            x = square[((r1 + shift) % pfc_pkg::SQ_SIDE) * pfc_pkg::SQ_SIDE + c1];
            y = square[((r2 + shift) % pfc_pkg::SQ_SIDE) * pfc_pkg::SQ_SIDE + c2];
         end else begin
            x = square[r1 * pfc_pkg::SQ_SIDE + c2];
            y = square[r2 * pfc_pkg::SQ_SIDE + c1];
         end
         letters_due.push_back('{letter: pfc_pkg::LETTER_A + 7'(x), last: 1'b0});
         letters_due.push_back('{letter: pfc_pkg::LETTER_A + 7'(y), last: 1'b1});
      endfunction

      // returns 1 for every keyword word, and for any other word that changes state or yields letters
      function bit accept_word(pfc_pkg::mode_type m, logic [7:0] ch);
         logic [4:0] idx;
         bit         is_letter;
         is_letter = letter_index(ch, idx);
         case (m)
            pfc_pkg::MODE_KEY: begin
               if (ready) restart_key();
               if (is_letter) place(idx);
               return 1'b1;
            end
            pfc_pkg::MODE_FIN: begin
               if (ready) return 1'b0;
               for (int i = 0; i < pfc_pkg::ALPHA; i++) place(5'(i));
               ready = 1'b1;
               return 1'b1;
            end
            pfc_pkg::MODE_TEXT: begin
               if (!ready || !is_letter) return 1'b0;
               if (!held_v) begin
                  held   = idx;
                  held_v = 1'b1;
               end else if (idx == held) begin
                  // doubled letter: pad with X and keep the second copy held
                  encipher_pair(held, pfc_pkg::IDX_X);
               end else begin
                  held_v = 1'b0;
                  encipher_pair(held, idx);
               end
               return 1'b1;
            end
            default: begin
               if (!ready || !held_v) return 1'b0;
               held_v = 1'b0;
               encipher_pair(held, pfc_pkg::IDX_X);
               return 1'b1;
            end
         endcase
      endfunction

      task take_letter(logic [6:0] letter, logic last);
         cipher_letter_type want;
         if (letters_due.size() == 0) begin
            report($sformatf("unexpected letter 0x%02h last %0b", letter, last));
            return;
         end
         want = letters_due.pop_front();
         if (letter !== want.letter)
            report($sformatf("letter 0x%02h, want 0x%02h", letter, want.letter));
         if (last !== want.last)
            report($sformatf("last %0b, want %0b", last, want.last));
      endtask
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = 16'd0;   // [1:0] mode, [9:2] char_in, rest zero
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;             // [6:0] letter, [7] zero
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;

   playfair_tracker tracker = new();
   bit          quiet;
   int          effective_words;
   int          stall_left = 0;
   logic [7:0]  prev_char;

   playfair_cipher_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   always @(posedge clock) begin
      int n;
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
         n = pick_gap();
         stall_left = (n > 0) ? n - 1 : 0;
         rsp_tready <= (n == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.take_letter(rsp_tdata[6:0], rsp_tlast);
   end

   // call at a rising edge; returns at the edge that accepts the word
   task automatic send_word(pfc_pkg::mode_type m, logic [7:0] ch);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, ch, m};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (tracker.accept_word(m, ch)) effective_words++;
   endtask

   // drop valid, wait for every letter, then let any fill walk finish
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.letters_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_decrypt(bit v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.decrypt = v;
      @(posedge clock);
   endtask

   // letters of either case, repeats and J now and then, some raw bytes
   function automatic logic [7:0] pick_char();
      int r;
      logic [7:0] c;
      r = $urandom_range(0, 99);
      if (r < 12) return 8'($urandom_range(0, 255));
      if (r < 22) return prev_char;
      if (r < 27) c = "J";
      else c = 8'("A" + $urandom_range(0, 25));
      if ($urandom_range(0, 1)) c = c | 8'h20;
      prev_char = c;
      return c;
   endfunction

   task automatic run_directed();
      // text before a key is ignored while no key is finished
      send_word(pfc_pkg::MODE_TEXT, "A");
      send_word(pfc_pkg::MODE_END, 8'h00);
      send_word(pfc_pkg::MODE_KEY, 8'h00);
      send_word(pfc_pkg::MODE_KEY, 8'hFF);
      send_word(pfc_pkg::MODE_KEY, "P");
      send_word(pfc_pkg::MODE_KEY, "l");
      send_word(pfc_pkg::MODE_KEY, "a");
      send_word(pfc_pkg::MODE_KEY, "Y");
      send_word(pfc_pkg::MODE_KEY, "J");
      send_word(pfc_pkg::MODE_KEY, "i");
      send_word(pfc_pkg::MODE_KEY, "z");
      send_word(pfc_pkg::MODE_FIN, 8'hFF);
      send_word(pfc_pkg::MODE_FIN, 8'h00);
      send_word(pfc_pkg::MODE_TEXT, 8'h80);
      send_word(pfc_pkg::MODE_TEXT, "h");
      send_word(pfc_pkg::MODE_TEXT, "E");
      send_word(pfc_pkg::MODE_TEXT, "l");
      send_word(pfc_pkg::MODE_TEXT, "L");
      send_word(pfc_pkg::MODE_TEXT, "o");
      send_word(pfc_pkg::MODE_TEXT, "J");
      send_word(pfc_pkg::MODE_TEXT, "i");
      send_word(pfc_pkg::MODE_TEXT, "x");
      send_word(pfc_pkg::MODE_TEXT, "X");
      send_word(pfc_pkg::MODE_END, 8'h00);
      send_word(pfc_pkg::MODE_END, 8'h00);
      send_word(pfc_pkg::MODE_TEXT, "1");
      send_word(pfc_pkg::MODE_TEXT, "a");
      // keyword over a finished key drops the held letter
      send_word(pfc_pkg::MODE_KEY, "#");
      send_word(pfc_pkg::MODE_FIN, 8'h00);
      send_word(pfc_pkg::MODE_TEXT, "q");
      send_word(pfc_pkg::MODE_END, 8'h00);
   endtask

   task automatic run_phase();
      int pick, kw_len, txt_len;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         repeat ($urandom_range(5, 25))
            send_word(pfc_pkg::mode_type'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255)));
         return;
      end
      kw_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      repeat (kw_len) send_word(pfc_pkg::MODE_KEY, pick_char());
      // a broken sequence now and then: no finish, so the text is ignored
      if (pick != 1) send_word(pfc_pkg::MODE_FIN, 8'($urandom_range(0, 255)));
      txt_len = $urandom_range(0, 40);
      repeat (txt_len) send_word(pfc_pkg::MODE_TEXT, pick_char());
      if ($urandom_range(0, 7) != 0) send_word(pfc_pkg::MODE_END, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      quiet           = 1'b0;
      effective_words = 0;
      prev_char       = "A";
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_decrypt(1'b0);
      run_directed();
      drain();
      write_decrypt(1'b1);
      run_directed();
      drain();
      while (effective_words < ITEM_TARGET) begin
         quiet = ($urandom_range(0, 5) == 0);
         write_decrypt(1'($urandom_range(0, 1)));
         run_phase();
         drain();
      end
      if (tracker.letters_due.size() != 0)
         tracker.report("letters still expected at end of run");
      if (tracker.fails == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

/* sim.f */
hdl/pfc_pkg.sv
hdl/pfc_ctrl.sv
hdl/pfc_dp.sv
hdl/playfair_cipher_engine.sv
verif/tb_top.sv
